// ===== hdl/cvto_pkg.sv =====
`timescale 1ns / 1ps

package cvto_pkg;

    localparam int MAX_OBJECTS = 1024;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_QUAT  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_X_GAIN   = 3'd0;
    localparam logic [2:0] CFG_X_BIAS   = 3'd1;
    localparam logic [2:0] CFG_Y_GAIN   = 3'd2;
    localparam logic [2:0] CFG_Y_BIAS   = 3'd3;
    localparam logic [2:0] CFG_Z_GAIN   = 3'd4;
    localparam logic [2:0] CFG_Z_BIAS   = 3'd5;
    localparam logic [2:0] CFG_NORM_TOL = 3'd6;

    localparam logic [2:0] LAST_FACE   = 3'd5;
    localparam logic [1:0] LAST_CORNER = 2'd3;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic signed [31:0] size_z;
    } pose_t;

    typedef struct packed {
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic [10:0]        object_number;
        logic [2:0]         face;
        logic [1:0]         corner;
        logic [14:0]        vertex_number;
        logic [2:0]         status;
        logic               last;
    } vert_t;

    typedef struct packed {
        pose_t       pose;
        logic [2:0]  status;
        logic [10:0] obj;
        logic [14:0] vbase;
    } job_t;

    typedef struct packed {
        logic signed [31:0] x_gain;
        logic signed [31:0] x_bias;
        logic signed [31:0] y_gain;
        logic signed [31:0] y_bias;
        logic signed [31:0] z_gain;
        logic signed [31:0] z_bias;
    } clip_cfg_t;

    // negative axes of a corner, bit 0 x, bit 1 y, bit 2 z
    function automatic logic [2:0] corner_neg(input logic [2:0] face, input logic [1:0] corner);
        logic [2:0] r;
        case ({face, corner})
            5'd0:    r = 3'b110;
            5'd1:    r = 3'b100;
            5'd2:    r = 3'b000;
            5'd3:    r = 3'b010;
            5'd4:    r = 3'b011;
            5'd5:    r = 3'b001;
            5'd6:    r = 3'b101;
            5'd7:    r = 3'b111;
            5'd8:    r = 3'b101;
            5'd9:    r = 3'b001;
            5'd10:   r = 3'b000;
            5'd11:   r = 3'b100;
            5'd12:   r = 3'b011;
            5'd13:   r = 3'b111;
            5'd14:   r = 3'b110;
            5'd15:   r = 3'b010;
            5'd16:   r = 3'b011;
            5'd17:   r = 3'b010;
            5'd18:   r = 3'b000;
            5'd19:   r = 3'b001;
            5'd20:   r = 3'b110;
            5'd21:   r = 3'b111;
            5'd22:   r = 3'b101;
            5'd23:   r = 3'b100;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/cvto_front.sv =====
`timescale 1ns / 1ps

module cvto_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pose_valid,
    output logic              pose_ready,
    input  cvto_pkg::pose_t   pose,
    input  logic [15:0]       norm_tol,
    output logic              job_valid,
    input  logic              job_ready,
    output cvto_pkg::job_t    job
);

    typedef enum logic [1:0] {F_IDLE, F_SQR, F_CLS} fstate_t;

    localparam logic [64:0] ONE60 = 65'h1000000000000000;

    fstate_t          state_reg;
    logic [10:0]      count_reg;
    cvto_pkg::pose_t  pose_reg;
    logic [63:0]      sq_reg [4];

    logic signed [63:0] sq_next [4];
    logic [64:0]      sum;
    logic [64:0]      dev;
    logic [64:0]      tol_lim;
    logic             quat_bad;
    logic             scale_bad;
    logic             full;
    logic [2:0]       status;
    logic [14:0]      cnt15;

    assign sq_next[0] = pose_reg.quat_x * pose_reg.quat_x;
    assign sq_next[1] = pose_reg.quat_y * pose_reg.quat_y;
    assign sq_next[2] = pose_reg.quat_z * pose_reg.quat_z;
    assign sq_next[3] = pose_reg.quat_w * pose_reg.quat_w;

    assign sum = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
    assign dev = (sum >= ONE60) ? (sum - ONE60) : (ONE60 - sum);
    assign tol_lim = {19'd0, norm_tol, 30'd0};
    assign quat_bad = sum[64] || (dev > tol_lim);
    assign scale_bad = (pose_reg.size_x == '0) || (pose_reg.size_y == '0)
                    || (pose_reg.size_z == '0);
    assign full = count_reg >= 11'(cvto_pkg::MAX_OBJECTS);

    always_comb
    begin
        if (quat_bad)
            status = cvto_pkg::ST_QUAT;
        else if (scale_bad)
            status = cvto_pkg::ST_SCALE;
        else if (full)
            status = cvto_pkg::ST_FULL;
        else
            status = cvto_pkg::ST_OK;
    end

    assign cnt15 = {4'd0, count_reg};

    assign pose_ready = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_CLS);
    assign job.pose = pose_reg;
    assign job.status = status;
    assign job.obj = count_reg + 11'd1;
    assign job.vbase = (cnt15 << 4) + (cnt15 << 3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (pose_valid)
                        state_reg <= F_SQR;
                end
                F_SQR:
                begin
                    state_reg <= F_CLS;
                end
                F_CLS:
                begin
                    if (job_ready)
                    begin
                        state_reg <= F_IDLE;
                        if (status == cvto_pkg::ST_OK)
                            count_reg <= count_reg + 11'd1;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pose_valid && pose_ready)
            pose_reg <= pose;
        if (state_reg == F_SQR)
        begin
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= sq_next[i];
        end
    end

endmodule

// ===== hdl/cvto_fifo.sv =====
`timescale 1ns / 1ps

module cvto_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  cvto_pkg::job_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output cvto_pkg::job_t  rd_data
);

    cvto_pkg::job_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hdl/cvto_back.sv =====
`timescale 1ns / 1ps

module cvto_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  cvto_pkg::job_t       job,
    input  cvto_pkg::clip_cfg_t  ccfg,
    output logic                 vert_valid,
    input  logic                 vert_ready,
    output cvto_pkg::vert_t      vert
);

    typedef enum logic [2:0] {B_IDLE, B_QMUL, B_MAT, B_SMUL, B_VERT} bstate_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] obj;
        logic [2:0]  face;
        logic [1:0]  corner;
        logic [14:0] vnum;
        logic        last;
    } meta_t;

    localparam logic [3:0] MUL_END = 4'd9;
    localparam logic signed [66:0] ONE60 = 67'sh1000000000000000;
    localparam logic signed [66:0] HALF30 = 67'sh20000000;
    localparam logic signed [66:0] HALF31 = 67'sh40000000;
    localparam logic signed [63:0] HALF16 = 64'sh8000;

    bstate_t        state_reg;
    logic [3:0]     cnt_reg;
    logic [2:0]     face_reg;
    logic [1:0]     corner_reg;
    logic           mul_wr_reg;
    logic           mul_dst_reg;
    logic [3:0]     mul_idx_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic           v3_reg;
    logic           vert_valid_reg;

    cvto_pkg::job_t     cur_reg;
    logic signed [64:0] mul_reg;
    logic signed [63:0] qp_reg [9];
    logic signed [32:0] m_reg [9];
    logic signed [64:0] p_reg [9];
    logic signed [66:0] acc_reg [3];
    logic signed [35:0] world_reg [3];
    logic signed [63:0] prod_reg [3];
    meta_t              meta1_reg;
    meta_t              meta2_reg;
    meta_t              meta3_reg;
    cvto_pkg::vert_t    vert_reg;

    logic               en;
    logic               pipe_busy;
    logic               take;
    logic               err_issue;
    logic               vert_issue;
    logic               issue;
    logic               at_last;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_next;
    logic signed [31:0] sz_w [3];
    logic signed [31:0] pos_w [3];
    logic signed [31:0] gain_w [3];
    logic signed [31:0] bias_w [3];
    logic signed [66:0] qe [9];
    logic signed [66:0] e_w [9];
    logic signed [66:0] er_w [9];
    logic signed [32:0] m_next [9];
    logic [2:0]         neg;
    logic signed [66:0] acc_next [3];
    logic signed [35:0] world_next [3];
    logic signed [63:0] prod_next [3];
    meta_t              meta_next;
    cvto_pkg::vert_t    vert_next;

    assign en = !vert_valid_reg || vert_ready;
    assign pipe_busy = v1_reg || v2_reg || v3_reg;
    assign job_ready = (state_reg == B_IDLE) && en && !pipe_busy;
    assign take = job_valid && job_ready;
    assign err_issue = take && (job.status != cvto_pkg::ST_OK);
    assign vert_issue = (state_reg == B_VERT) && en;
    assign issue = err_issue || vert_issue;
    assign at_last = (face_reg == cvto_pkg::LAST_FACE) && (corner_reg == cvto_pkg::LAST_CORNER);

    assign sz_w[0] = cur_reg.pose.size_x;
    assign sz_w[1] = cur_reg.pose.size_y;
    assign sz_w[2] = cur_reg.pose.size_z;
    assign pos_w[0] = cur_reg.pose.pos_x;
    assign pos_w[1] = cur_reg.pose.pos_y;
    assign pos_w[2] = cur_reg.pose.pos_z;
    assign gain_w[0] = ccfg.x_gain;
    assign gain_w[1] = ccfg.y_gain;
    assign gain_w[2] = ccfg.z_gain;
    assign bias_w[0] = ccfg.x_bias;
    assign bias_w[1] = ccfg.y_bias;
    assign bias_w[2] = ccfg.z_bias;

    // shared setup multiplier: quaternion products, then matrix times scale
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == B_SMUL)
        begin
            for (int k = 0; k < 9; k++)
            begin
                if (cnt_reg == 4'(k))
                begin
                    mul_a = m_reg[k];
                    mul_b = sz_w[k % 3];
                end
            end
        end
        else
        begin
            case (cnt_reg)
                4'd0:
                begin
                    mul_a = {cur_reg.pose.quat_x[31], cur_reg.pose.quat_x};
                    mul_b = cur_reg.pose.quat_x;
                end
                4'd1:
                begin
                    mul_a = {cur_reg.pose.quat_y[31], cur_reg.pose.quat_y};
                    mul_b = cur_reg.pose.quat_y;
                end
                4'd2:
                begin
                    mul_a = {cur_reg.pose.quat_z[31], cur_reg.pose.quat_z};
                    mul_b = cur_reg.pose.quat_z;
                end
                4'd3:
                begin
                    mul_a = {cur_reg.pose.quat_x[31], cur_reg.pose.quat_x};
                    mul_b = cur_reg.pose.quat_y;
                end
                4'd4:
                begin
                    mul_a = {cur_reg.pose.quat_z[31], cur_reg.pose.quat_z};
                    mul_b = cur_reg.pose.quat_w;
                end
                4'd5:
                begin
                    mul_a = {cur_reg.pose.quat_x[31], cur_reg.pose.quat_x};
                    mul_b = cur_reg.pose.quat_z;
                end
                4'd6:
                begin
                    mul_a = {cur_reg.pose.quat_y[31], cur_reg.pose.quat_y};
                    mul_b = cur_reg.pose.quat_w;
                end
                4'd7:
                begin
                    mul_a = {cur_reg.pose.quat_y[31], cur_reg.pose.quat_y};
                    mul_b = cur_reg.pose.quat_z;
                end
                4'd8:
                begin
                    mul_a = {cur_reg.pose.quat_x[31], cur_reg.pose.quat_x};
                    mul_b = cur_reg.pose.quat_w;
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_next = mul_a * mul_b;

    // rotation matrix, products xx yy zz xy zw xz yw yz xw
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            qe[k] = {{3{qp_reg[k][63]}}, qp_reg[k]};
        e_w[0] = ONE60 - ((qe[1] + qe[2]) <<< 1);
        e_w[1] = (qe[3] - qe[4]) <<< 1;
        e_w[2] = (qe[5] + qe[6]) <<< 1;
        e_w[3] = (qe[3] + qe[4]) <<< 1;
        e_w[4] = ONE60 - ((qe[0] + qe[2]) <<< 1);
        e_w[5] = (qe[7] - qe[8]) <<< 1;
        e_w[6] = (qe[5] - qe[6]) <<< 1;
        e_w[7] = (qe[7] + qe[8]) <<< 1;
        e_w[8] = ONE60 - ((qe[0] + qe[1]) <<< 1);
        for (int k = 0; k < 9; k++)
        begin
            er_w[k] = e_w[k] + HALF30;
            m_next[k] = er_w[k][62:30];
        end
    end

    // vertex pipeline
    assign neg = cvto_pkg::corner_neg(face_reg, corner_reg);

    always_comb
    begin
        logic signed [66:0] pe;
        logic signed [66:0] rr;
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = '0;
            for (int j = 0; j < 3; j++)
            begin
                pe = {{2{p_reg[i * 3 + j][64]}}, p_reg[i * 3 + j]};
                acc_next[i] = neg[j] ? (acc_next[i] - pe) : (acc_next[i] + pe);
            end
            rr = acc_reg[i] + HALF31;
            world_next[i] = {{4{pos_w[i][31]}}, pos_w[i]} + rr[66:31];
        end
    end

    always_comb
    begin
        logic signed [67:0] full_prod;
        for (int i = 0; i < 3; i++)
        begin
            full_prod = gain_w[i] * world_reg[i];
            prod_next[i] = full_prod[63:0];
        end
    end

    always_comb
    begin
        if (err_issue)
        begin
            meta_next.status = job.status;
            meta_next.obj = '0;
            meta_next.face = '0;
            meta_next.corner = '0;
            meta_next.vnum = '0;
            meta_next.last = 1'b1;
        end
        else
        begin
            meta_next.status = cvto_pkg::ST_OK;
            meta_next.obj = cur_reg.obj;
            meta_next.face = face_reg;
            meta_next.corner = corner_reg;
            meta_next.vnum = cur_reg.vbase + {10'd0, face_reg, corner_reg};
            meta_next.last = at_last;
        end
    end

    always_comb
    begin
        logic signed [63:0] t;
        logic signed [48:0] s;
        logic signed [31:0] c [3];
        logic               sat;
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            t = prod_reg[i] + HALF16;
            s = {t[63], t[63:16]} + {{17{bias_w[i][31]}}, bias_w[i]};
            if (!s[48] && (s[47:31] != '0))
            begin
                c[i] = 32'sh7FFFFFFF;
                sat = 1'b1;
            end
            else if (s[48] && (s[47:31] != '1))
            begin
                c[i] = 32'sh80000000;
                sat = 1'b1;
            end
            else
            begin
                c[i] = s[31:0];
            end
        end
        vert_next.object_number = meta3_reg.obj;
        vert_next.face = meta3_reg.face;
        vert_next.corner = meta3_reg.corner;
        vert_next.vertex_number = meta3_reg.vnum;
        vert_next.last = meta3_reg.last;
        if (meta3_reg.status != cvto_pkg::ST_OK)
        begin
            vert_next.clip_x = '0;
            vert_next.clip_y = '0;
            vert_next.clip_z = '0;
            vert_next.status = meta3_reg.status;
        end
        else
        begin
            vert_next.clip_x = c[0];
            vert_next.clip_y = c[1];
            vert_next.clip_z = c[2];
            vert_next.status = sat ? cvto_pkg::ST_SAT : cvto_pkg::ST_OK;
        end
    end

    assign vert_valid = vert_valid_reg;
    assign vert = vert_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg <= '0;
            face_reg <= '0;
            corner_reg <= '0;
            mul_wr_reg <= 1'b0;
            mul_dst_reg <= 1'b0;
            mul_idx_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vert_valid_reg <= 1'b0;
        end
        else
        begin
            mul_wr_reg <= ((state_reg == B_QMUL) || (state_reg == B_SMUL)) && (cnt_reg != MUL_END);
            mul_dst_reg <= (state_reg == B_SMUL);
            mul_idx_reg <= cnt_reg;
            if (en)
            begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                vert_valid_reg <= v3_reg;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (take && (job.status == cvto_pkg::ST_OK))
                    begin
                        state_reg <= B_QMUL;
                        cnt_reg <= '0;
                    end
                end
                B_QMUL:
                begin
                    if (cnt_reg == MUL_END)
                        state_reg <= B_MAT;
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                B_MAT:
                begin
                    state_reg <= B_SMUL;
                    cnt_reg <= '0;
                end
                B_SMUL:
                begin
                    if (cnt_reg == MUL_END)
                    begin
                        state_reg <= B_VERT;
                        face_reg <= '0;
                        corner_reg <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                B_VERT:
                begin
                    if (en)
                    begin
                        if (at_last)
                            state_reg <= B_IDLE;
                        else if (corner_reg == cvto_pkg::LAST_CORNER)
                        begin
                            corner_reg <= '0;
                            face_reg <= face_reg + 3'd1;
                        end
                        else
                        begin
                            corner_reg <= corner_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= job;
        mul_reg <= mul_next;
        if (mul_wr_reg)
        begin
            if (mul_dst_reg)
                p_reg[mul_idx_reg] <= mul_reg;
            else
                qp_reg[mul_idx_reg] <= mul_reg[63:0];
        end
        if (state_reg == B_MAT)
        begin
            for (int k = 0; k < 9; k++)
                m_reg[k] <= m_next[k];
        end
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= acc_next[i];
                world_reg[i] <= world_next[i];
                prod_reg[i] <= prod_next[i];
            end
            meta1_reg <= meta_next;
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
            if (v3_reg)
                vert_reg <= vert_next;
        end
    end

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid_reg && (vert_reg.status != cvto_pkg::ST_OK)
        && (vert_reg.status != cvto_pkg::ST_SAT)
        |-> vert_reg.last && (vert_reg.object_number == '0))
        else $error("error result not single");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid_reg && vert_reg.last
        && ((vert_reg.status == cvto_pkg::ST_OK) || (vert_reg.status == cvto_pkg::ST_SAT))
        |-> (vert_reg.face == cvto_pkg::LAST_FACE) && (vert_reg.corner == cvto_pkg::LAST_CORNER))
        else $error("last flag on wrong vertex");

    a_mat_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_MAT) |-> !mul_wr_reg)
        else $error("matrix formed before products captured");

    a_no_issue_setup: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == B_QMUL) || (state_reg == B_SMUL)) |=> !v1_reg || !$stable(state_reg)
        || (state_reg == B_VERT))
        else $error("vertex issued during setup");

endmodule

// ===== hdl/cube_vertex_transform_ortho.sv =====
`timescale 1ns / 1ps
// per valid object: 18 products on the shared multiplier during setup, then 24 vertices at one
// per cycle through a 4 stage pipeline while the output is not stalled; the next job is taken
// only once the pipeline has drained
// invalid poses pass through the pipeline one at a time; a 2 entry queue lets the checker run ahead
// reset: asynchronous active low, clears the object counter and restores clip registers

module cube_vertex_transform_ortho
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pose_valid,
    output logic              pose_ready,
    input  cvto_pkg::pose_t   pose,
    output logic              vert_valid,
    input  logic              vert_ready,
    output cvto_pkg::vert_t   vert,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    cvto_pkg::clip_cfg_t ccfg_reg;
    logic [15:0]         norm_tol_reg;

    logic            fj_valid;
    logic            fj_ready;
    cvto_pkg::job_t  fj;
    logic            bj_valid;
    logic            bj_ready;
    cvto_pkg::job_t  bj;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccfg_reg.x_gain <= 32'sh00010000;
            ccfg_reg.x_bias <= '0;
            ccfg_reg.y_gain <= 32'shFFFF0000;
            ccfg_reg.y_bias <= '0;
            ccfg_reg.z_gain <= 32'shFFFF0000;
            ccfg_reg.z_bias <= '0;
            norm_tol_reg <= 16'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cvto_pkg::CFG_X_GAIN:   ccfg_reg.x_gain <= cfg_data;
                cvto_pkg::CFG_X_BIAS:   ccfg_reg.x_bias <= cfg_data;
                cvto_pkg::CFG_Y_GAIN:   ccfg_reg.y_gain <= cfg_data;
                cvto_pkg::CFG_Y_BIAS:   ccfg_reg.y_bias <= cfg_data;
                cvto_pkg::CFG_Z_GAIN:   ccfg_reg.z_gain <= cfg_data;
                cvto_pkg::CFG_Z_BIAS:   ccfg_reg.z_bias <= cfg_data;
                cvto_pkg::CFG_NORM_TOL: norm_tol_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    cvto_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pose_valid (pose_valid),
        .pose_ready (pose_ready),
        .pose       (pose),
        .norm_tol   (norm_tol_reg),
        .job_valid  (fj_valid),
        .job_ready  (fj_ready),
        .job        (fj)
    );

    cvto_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_data  (bj)
    );

    cvto_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (bj_valid),
        .job_ready  (bj_ready),
        .job        (bj),
        .ccfg       (ccfg_reg),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .vert       (vert)
    );

endmodule

// ===== verif/cube_vertex_transform_ortho_tb.sv =====
`timescale 1ns / 1ps

module cube_vertex_transform_ortho_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;

    // negative axes per corner in face-major order, bit 0 x, bit 1 y, bit 2 z
    localparam bit [2:0] CORNER_NEG [24] = '{
        3'b110, 3'b100, 3'b000, 3'b010,
        3'b011, 3'b001, 3'b101, 3'b111,
        3'b101, 3'b001, 3'b000, 3'b100,
        3'b011, 3'b111, 3'b110, 3'b010,
        3'b011, 3'b010, 3'b000, 3'b001,
        3'b110, 3'b111, 3'b101, 3'b100
    };

    logic              clk;
    logic              rst_n;
    logic              pose_valid;
    logic              pose_ready;
    cvto_pkg::pose_t   pose;
    logic              vert_valid;
    logic              vert_ready;
    cvto_pkg::vert_t   vert;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;

    // shadow of the block's registers and object counter
    logic signed [31:0] clip_gain [3];
    logic signed [31:0] clip_bias [3];
    logic [15:0]        norm_tol;
    int unsigned        objects_done;

    cvto_pkg::pose_t pose_pending_q [$];
    cvto_pkg::vert_t vert_expect_q  [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int idle_cycles;
    int poses_sent;
    int verts_checked;
    int error_results;
    int saturated_verts;

    cube_vertex_transform_ortho DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pose_valid (pose_valid),
        .pose_ready (pose_ready),
        .pose       (pose),
        .vert_valid (vert_valid),
        .vert_ready (vert_ready),
        .vert       (vert),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [127:0] round_down_shift(input logic signed [127:0] v,
                                                              input int n);
        return (v + (128'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic void expect_vert(input cvto_pkg::vert_t v);
        vert_expect_q = {vert_expect_q, v};
    endfunction

    function automatic void queue_pose(input cvto_pkg::pose_t p);
        pose_pending_q = {pose_pending_q, p};
    endfunction

    function automatic cvto_pkg::vert_t error_vert(input logic [2:0] code);
        cvto_pkg::vert_t r;
        r = '0;
        r.status = code;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic expect_cube_for_pose(input cvto_pkg::pose_t p);
        logic signed [127:0] q [4];
        logic signed [127:0] sz [3];
        logic signed [127:0] ps [3];
        logic signed [127:0] e [3][3];
        logic signed [127:0] m [3][3];
        logic signed [127:0] l [3];
        logic signed [127:0] acc, world, c;
        logic signed [127:0] one60;
        logic signed [63:0] prod64, t64;
        logic [127:0] sq_sum, dev;
        logic signed [31:0] clip [3];
        cvto_pkg::vert_t v;
        bit sat;
        int k;
        q[0] = p.quat_x; q[1] = p.quat_y; q[2] = p.quat_z; q[3] = p.quat_w;
        sz[0] = p.size_x; sz[1] = p.size_y; sz[2] = p.size_z;
        ps[0] = p.pos_x; ps[1] = p.pos_y; ps[2] = p.pos_z;
        one60 = 128'sd1 <<< 60;
        sq_sum = q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
        dev = (sq_sum >= one60) ? sq_sum - one60 : one60 - sq_sum;
        if (sq_sum >= (128'd1 << 64) || dev > ({112'd0, norm_tol} << 30))
        begin
            expect_vert(error_vert(cvto_pkg::ST_QUAT));
            return;
        end
        if (sz[0] == 0 || sz[1] == 0 || sz[2] == 0)
        begin
            expect_vert(error_vert(cvto_pkg::ST_SCALE));
            return;
        end
        if (objects_done >= cvto_pkg::MAX_OBJECTS)
        begin
            expect_vert(error_vert(cvto_pkg::ST_FULL));
            return;
        end
        e[0][0] = one60 - 2 * (q[1] * q[1] + q[2] * q[2]);
        e[0][1] = 2 * (q[0] * q[1] - q[2] * q[3]);
        e[0][2] = 2 * (q[0] * q[2] + q[1] * q[3]);
        e[1][0] = 2 * (q[0] * q[1] + q[2] * q[3]);
        e[1][1] = one60 - 2 * (q[0] * q[0] + q[2] * q[2]);
        e[1][2] = 2 * (q[1] * q[2] - q[0] * q[3]);
        e[2][0] = 2 * (q[0] * q[2] - q[1] * q[3]);
        e[2][1] = 2 * (q[1] * q[2] + q[0] * q[3]);
        e[2][2] = one60 - 2 * (q[0] * q[0] + q[1] * q[1]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = round_down_shift(e[i][j], 30);
        for (k = 0; k < 24; k++)
        begin
            sat = 1'b0;
            for (int j = 0; j < 3; j++)
                l[j] = CORNER_NEG[k][j] ? -sz[j] : sz[j];
            for (int i = 0; i < 3; i++)
            begin
                acc = m[i][0] * l[0] + m[i][1] * l[1] + m[i][2] * l[2];
                world = ps[i] + round_down_shift(acc, 31);
                // gain product and rounding wrap at 64 bits
                prod64 = 64'(clip_gain[i] * world);
                t64 = prod64 + 64'sd32768;
                c = (t64 >>> 16) + clip_bias[i];
                if (c > 128'sd2147483647)
                begin
                    sat = 1'b1;
                    clip[i] = 32'h7fffffff;
                end
                else if (c < -128'sd2147483648)
                begin
                    sat = 1'b1;
                    clip[i] = 32'h80000000;
                end
                else
                    clip[i] = c[31:0];
            end
            v.clip_x = clip[0];
            v.clip_y = clip[1];
            v.clip_z = clip[2];
            v.object_number = 11'(objects_done + 1);
            v.face = 3'(k / 4);
            v.corner = 2'(k % 4);
            v.vertex_number = 15'(objects_done * 24 + k);
            v.status = sat ? cvto_pkg::ST_SAT : cvto_pkg::ST_OK;
            v.last = (k == 23);
            expect_vert(v);
        end
        objects_done = (objects_done + 1) & 11'h7ff;
    endtask

    function automatic real rand_unit();
        return (real'($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
    endfunction

    function automatic logic signed [31:0] rand_nonzero_size(input bit huge);
        logic signed [31:0] s;
        if (huge)
            s = $urandom;
        else
            s = $urandom_range(1, 8 << 16);
        if (s == 0)
            s = 1;
        if (!huge && $urandom_range(0, 1))
            s = -s;
        return s;
    endfunction

    function automatic cvto_pkg::pose_t unit_pose(input bit huge);
        cvto_pkg::pose_t p;
        real v [4];
        real n;
        n = 1.0e-3;
        for (int i = 0; i < 4; i++)
        begin
            v[i] = rand_unit();
            n += v[i] * v[i];
        end
        n = $sqrt(n);
        p.quat_x = $rtoi(v[0] / n * 1073741824.0);
        p.quat_y = $rtoi(v[1] / n * 1073741824.0);
        p.quat_z = $rtoi(v[2] / n * 1073741824.0);
        p.quat_w = $rtoi(v[3] / n * 1073741824.0);
        if (huge)
        begin
            p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
        end
        else
        begin
            p.pos_x = $urandom_range(0, 200 << 16) - (100 << 16);
            p.pos_y = $urandom_range(0, 200 << 16) - (100 << 16);
            p.pos_z = $urandom_range(0, 200 << 16) - (100 << 16);
        end
        p.size_x = rand_nonzero_size(huge);
        p.size_y = rand_nonzero_size(huge);
        p.size_z = rand_nonzero_size(huge);
        return p;
    endfunction

    function automatic cvto_pkg::pose_t random_pose();
        cvto_pkg::pose_t p;
        int pick;
        pick = $urandom_range(0, 99);
        p = unit_pose(pick < 15);
        if (pick >= 80 && pick < 90)
            p = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom};
        else if (pick >= 90 && pick < 95)
        begin
            case ($urandom_range(0, 2))
                0: p.size_x = '0;
                1: p.size_y = '0;
                default: p.size_z = '0;
            endcase
        end
        else if (pick >= 95)
            p.quat_w = p.quat_w + $signed($urandom_range(0, 4096)) - 2048;
        return p;
    endfunction

    function automatic cvto_pkg::pose_t axis_pose(input logic signed [31:0] qx, qy, qz, qw);
        cvto_pkg::pose_t p;
        p.pos_x = 32'sd65536; p.pos_y = -32'sd131072; p.pos_z = 32'sd0;
        p.quat_x = qx; p.quat_y = qy; p.quat_z = qz; p.quat_w = qw;
        p.size_x = 32'sd65536; p.size_y = 32'sd131072; p.size_z = 32'sd32768;
        return p;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cvto_pkg::CFG_X_GAIN:   clip_gain[0] = data;
            cvto_pkg::CFG_X_BIAS:   clip_bias[0] = data;
            cvto_pkg::CFG_Y_GAIN:   clip_gain[1] = data;
            cvto_pkg::CFG_Y_BIAS:   clip_bias[1] = data;
            cvto_pkg::CFG_Z_GAIN:   clip_gain[2] = data;
            cvto_pkg::CFG_Z_BIAS:   clip_bias[2] = data;
            cvto_pkg::CFG_NORM_TOL: norm_tol = data[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] xg, xb, yg, yb, zg, zb, tol);
        write_reg(cvto_pkg::CFG_X_GAIN, xg);
        write_reg(cvto_pkg::CFG_X_BIAS, xb);
        write_reg(cvto_pkg::CFG_Y_GAIN, yg);
        write_reg(cvto_pkg::CFG_Y_BIAS, yb);
        write_reg(cvto_pkg::CFG_Z_GAIN, zg);
        write_reg(cvto_pkg::CFG_Z_BIAS, zb);
        write_reg(cvto_pkg::CFG_NORM_TOL, tol);
    endtask

    task automatic wait_drained();
        while (pose_pending_q.size() != 0 || pose_valid || vert_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) queue_pose(random_pose());
    endtask

    task automatic check_field(input string nm, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", nm, want, got);
            fail_count++;
        end
    endtask

    // pose driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_valid <= 1'b0;
            pose       <= '0;
        end
        else
        begin
            if (pose_valid && pose_ready)
            begin
                expect_cube_for_pose(pose);
                poses_sent++;
            end
            if (!pose_valid || pose_ready)
            begin
                if (pose_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    pose_valid <= 1'b1;
                    pose       <= pose_pending_q.pop_front();
                end
                else
                    pose_valid <= 1'b0;
            end
        end
    end

    // vertex monitor and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        cvto_pkg::vert_t want;
        if (!rst_n)
        begin
            vert_ready  <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            vert_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (vert_valid && vert_ready)
            begin
                if (vert_expect_q.size() == 0)
                begin
                    $error("unexpected vertex transaction");
                    fail_count++;
                end
                else
                begin
                    want = vert_expect_q.pop_front();
                    check_field("clip_x", want.clip_x, vert.clip_x);
                    check_field("clip_y", want.clip_y, vert.clip_y);
                    check_field("clip_z", want.clip_z, vert.clip_z);
                    check_field("object_number", want.object_number, vert.object_number);
                    check_field("face", want.face, vert.face);
                    check_field("corner", want.corner, vert.corner);
                    check_field("vertex_number", want.vertex_number, vert.vertex_number);
                    check_field("status", want.status, vert.status);
                    check_field("last", want.last, vert.last);
                    verts_checked++;
                    if (want.status == cvto_pkg::ST_SAT)
                        saturated_verts++;
                    else if (want.status != cvto_pkg::ST_OK)
                        error_results++;
                end
            end
            if ((pose_valid && pose_ready) || (vert_valid && vert_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        cvto_pkg::pose_t p;
        rst_n          = 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= cvto_pkg::CFG_X_GAIN;
        cfg_data       <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        poses_sent     = 0;
        verts_checked  = 0;
        error_results  = 0;
        saturated_verts = 0;
        objects_done   = 0;
        clip_gain[0] = 32'sd65536;  clip_bias[0] = '0;
        clip_gain[1] = -32'sd65536; clip_bias[1] = '0;
        clip_gain[2] = -32'sd65536; clip_bias[2] = '0;
        norm_tol = 16'd16;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed poses under reset configuration
        queue_pose(axis_pose(0, 0, 0, 32'sd1073741824));
        queue_pose(axis_pose(0, 0, 0, -32'sd1073741824));
        queue_pose(axis_pose(32'sd1073741824, 0, 0, 0));
        queue_pose(axis_pose(0, 32'sd1073741824, 0, 0));
        queue_pose(axis_pose(0, 0, 32'sd759250125, 32'sd759250125));
        queue_pose(axis_pose(32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000));
        queue_pose(axis_pose(32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff));
        queue_pose(axis_pose(0, 0, 0, 32'sd1073741824 + 32'sd64));
        queue_pose(axis_pose(0, 0, 0, 0));
        p = axis_pose(0, 0, 0, 32'sd1073741824);
        p.size_x = '0;
        queue_pose(p);
        p = axis_pose(0, 0, 0, 32'sd1073741824);
        p.size_y = '0;
        queue_pose(p);
        p = axis_pose(0, 0, 0, 32'sd1073741824);
        p.size_z = '0;
        queue_pose(p);
        p.quat_w = '0;
        queue_pose(p);
        p = axis_pose(0, 0, 0, 32'sd1073741824);
        p.size_x = 32'h7fffffff; p.size_y = 32'h80000000; p.size_z = 32'h7fffffff;
        queue_pose(p);
        p.pos_x = 32'h7fffffff; p.pos_y = 32'h80000000; p.pos_z = 32'h80000000;
        queue_pose(p);
        p = axis_pose(0, 0, 0, 32'sd1073741824);
        p.size_x = 32'sd1; p.size_y = -32'sd1; p.size_z = 32'sd1;
        p.pos_x = 32'h80000000; p.pos_y = 32'h7fffffff; p.pos_z = 32'h7fffffff;
        queue_pose(p);
        queue_pose(unit_pose(1'b0));
        queue_pose(unit_pose(1'b1));
        wait_drained();

        send_idle_pct = 0; recv_stall_pct = 0;
        write_all(32'h00008000, 32'h00001000, 32'hffff4000, 32'hfffff000,
                  32'h00002000, 32'h00008000, 32'd16);
        queue_random(40);
        wait_drained();

        send_idle_pct = 65; recv_stall_pct = 0;
        write_all(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  32'h00000000, 32'h7fffffff, 32'd65535);
        queue_random(35);
        wait_drained();

        send_idle_pct = 0; recv_stall_pct = 65;
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'd0);
        queue_random(35);
        wait_drained();

        send_idle_pct = 10; recv_stall_pct = 10;
        write_all(32'h00010000 + $urandom_range(0, 65535), $urandom_range(0, 65535),
                  32'hffff0000 - $urandom_range(0, 65535), $urandom_range(0, 65535),
                  32'hffff8000, $urandom_range(0, 65535), $urandom_range(1, 64));
        queue_random(15);
        // hold the sender until the block has emptied
        wait_drained();
        queue_random(20);
        wait_drained();

        // mixed tail under the reset mapping
        write_all(32'h00010000, 32'h0, 32'hffff0000, 32'h0, 32'hffff0000, 32'h0,
                  32'd65535);
        queue_pose(unit_pose(1'b0));
        queue_pose(axis_pose(0, 0, 0, 0));
        p = unit_pose(1'b0);
        p.size_y = '0;
        queue_pose(p);
        queue_pose(unit_pose(1'b1));
        wait_drained();

        $display("covered %0d poses and %0d results across four handshake idling mixes",
                 poses_sent, verts_checked);
        $display("%0d error results, %0d saturated vertices, %0d objects accepted",
                 error_results, saturated_verts, objects_done);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
